@@ src/sfe_pkg.sv @@
// Shared types, constants and the FNV-1a step for the SimHash fingerprint engine.
package sfe_pkg;

    // FNV-1a 64-bit constants
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    // Fingerprint and configuration widths
    localparam int FP_W          = 64;
    localparam int HB_W          = 7;
    localparam int WEIGHT_W      = 16;
    localparam int MIN_HASH_BITS = 8;
    localparam logic [HB_W-1:0] HASH_BITS_RST = 7'd64;

    // One input item
    typedef struct packed {
        logic [7:0]                 data_byte;
        logic                       byte_valid;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last_of_feature;
        logic                       last_of_document;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [FP_W-1:0] fingerprint;
        logic            saturated;
    } out_item_t;

    // Command passed from the hashing front to the accumulator back
    typedef struct packed {
        logic [63:0]                hash;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       apply;
        logic                       doc_end;
    } feat_cmd_t;

    // One FNV-1a byte step; the prime is 2^40 + 0x1B3, so shifts and adds suffice
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ src/sfe_front.sv @@
// Front end: accepts items, runs the FNV-1a hash and issues feature commands.
module sfe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sfe_pkg::in_item_t  item,
    input  logic               q_full,
    output logic               q_push,
    output sfe_pkg::feat_cmd_t q_data
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [63:0] hash_step;
    logic        accept;

    // Hold off new items while the queue has no room
    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    // Fold this item's byte into the running hash
    assign hash_step = item.byte_valid ? sfe_pkg::fnv_step(hash_reg, item.data_byte)
                                       : hash_reg;

    // Issue a command at feature end or document end
    always_comb
    begin
        q_push         = accept && (item.last_of_feature || item.last_of_document);
        q_data.hash    = hash_step;
        q_data.weight  = item.weight;
        q_data.apply   = item.last_of_feature;
        q_data.doc_end = item.last_of_document;
    end

    // Advance the hash; restart it after a feature or document ends
    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (item.last_of_feature || item.last_of_document)
                hash_next = sfe_pkg::FNV_BASIS;
            else
                hash_next = hash_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= sfe_pkg::FNV_BASIS;
        else
            hash_reg <= hash_next;
    end

endmodule

@@ src/sfe_queue.sv @@
// Two-entry command queue between the hashing front and the accumulator back.
module sfe_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sfe_pkg::feat_cmd_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output sfe_pkg::feat_cmd_t head
);

    sfe_pkg::feat_cmd_t entry_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/sfe_back.sv @@
// Back end: saturating accumulators, fingerprint formation and output register.
module sfe_back #(
    parameter int MAX_HASH_BITS = 64,
    parameter int ACC_WIDTH     = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sfe_pkg::HB_W-1:0] bits_used,
    input  logic                     head_valid,
    input  sfe_pkg::feat_cmd_t       head,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_stall,
    output sfe_pkg::out_item_t       result
);

    localparam int SUM_W = ACC_WIDTH + 1;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic [ACC_WIDTH-1:0]      acc_reg  [MAX_HASH_BITS];
    logic [ACC_WIDTH-1:0]      acc_upd  [MAX_HASH_BITS];
    logic [ACC_WIDTH-1:0]      acc_next [MAX_HASH_BITS];
    logic [MAX_HASH_BITS-1:0]  lane_sat;
    logic                      sat_reg;
    logic                      sat_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    sfe_pkg::out_item_t        out_reg;
    logic [SUM_W-1:0]          w_ext;
    logic [sfe_pkg::FP_W-1:0]  fp;
    logic                      out_free;

    // Take a command unless it must emit and the output register is full
    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = head_valid && (!head.doc_end || out_free);

    assign w_ext = {{(SUM_W-sfe_pkg::WEIGHT_W){head.weight[sfe_pkg::WEIGHT_W-1]}},
                    head.weight};

    // Add or subtract the weight in every lane in use, with saturation
    always_comb
    begin
        logic [SUM_W-1:0] term;
        logic [SUM_W-1:0] sum;
        logic             lane_on;
        for (int i = 0; i < MAX_HASH_BITS; i++)
        begin
            term     = head.hash[i] ? w_ext : (~w_ext + SUM_W'(1));
            sum      = {acc_reg[i][ACC_WIDTH-1], acc_reg[i]} + term;
            lane_on  = head.apply && (sfe_pkg::HB_W'(i) < bits_used);
            acc_upd[i]  = acc_reg[i];
            lane_sat[i] = 1'b0;
            if (lane_on)
            begin
                if (!sum[SUM_W-1] && sum[SUM_W-2])
                begin
                    acc_upd[i]  = ACC_MAX;
                    lane_sat[i] = 1'b1;
                end
                else if (sum[SUM_W-1] && !sum[SUM_W-2])
                begin
                    acc_upd[i]  = ACC_MIN;
                    lane_sat[i] = 1'b1;
                end
                else
                begin
                    acc_upd[i] = sum[ACC_WIDTH-1:0];
                end
            end
        end
    end

    // Form the fingerprint from the updated lanes
    always_comb
    begin
        fp = '0;
        for (int i = 0; i < MAX_HASH_BITS; i++)
        begin
            fp[i] = (sfe_pkg::HB_W'(i) < bits_used) && !acc_upd[i][ACC_WIDTH-1]
                    && (|acc_upd[i]);
        end
    end

    // Commit the update; clear the document state on document end
    always_comb
    begin
        for (int i = 0; i < MAX_HASH_BITS; i++)
        begin
            acc_next[i] = acc_reg[i];
            if (pop)
                acc_next[i] = head.doc_end ? '0 : acc_upd[i];
        end
        sat_next = sat_reg;
        if (pop)
            sat_next = head.doc_end ? 1'b0 : (sat_reg || (|lane_sat));
    end

    // Load the output register on document end, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && head.doc_end)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_HASH_BITS; i++)
                acc_reg[i] <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_HASH_BITS; i++)
                acc_reg[i] <= acc_next[i];
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.doc_end)
        begin
            out_reg.fingerprint <= fp;
            out_reg.saturated   <= sat_reg || (|lane_sat);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ src/simhash_fingerprint_engine_top.sv @@
// SimHash fingerprint engine with FNV-1a feature hashing: top level.
//
// Usage:
//   item channel (item_valid / item_stall / item): one feature byte per item,
//   with the feature weight and the end-of-feature and end-of-document marks.
//   result channel (result_valid / result_stall / result): one fingerprint and
//   saturation flag per document, emitted on the item that ends the document.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes hash_bits; always
//   ready. Write it only while no document is in flight.
// Throughput: one item per cycle while item_stall is low; the front hashes one
//   byte per cycle, the back updates all accumulators in parallel, one command
//   per cycle unless a document end waits on a stalled result. Results pass
//   via the queue (hash stage) and the output register (accumulator update).
// Reset: hash restarts at the FNV offset basis, accumulators and the
//   saturation flag clear, hash_bits returns to 64, no result is pending.
// Stall: a stalled result holds in the output register; the back keeps taking
//   non-emitting commands, and the two-entry queue raises item_stall when full.
module simhash_fingerprint_engine_top #(
    parameter int MAX_HASH_BITS = 64,
    parameter int ACC_WIDTH     = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_stall,
    input  sfe_pkg::in_item_t        item,
    output logic                     result_valid,
    input  logic                     result_stall,
    output sfe_pkg::out_item_t       result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [sfe_pkg::HB_W-1:0] cfg_data
);

    logic [sfe_pkg::HB_W-1:0] hash_bits_reg;
    logic [sfe_pkg::HB_W-1:0] hash_bits_next;
    logic [sfe_pkg::HB_W-1:0] bits_used;
    logic                     q_full;
    logic                     q_push;
    sfe_pkg::feat_cmd_t       q_data;
    logic                     q_pop;
    logic                     q_head_valid;
    sfe_pkg::feat_cmd_t       q_head;

    // Configuration register
    assign cfg_ready      = 1'b1;
    assign hash_bits_next = cfg_valid ? cfg_data : hash_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_bits_reg <= sfe_pkg::HASH_BITS_RST;
        else
            hash_bits_reg <= hash_bits_next;
    end

    // Clamp the lane count to the supported range
    always_comb
    begin
        if (hash_bits_reg < sfe_pkg::HB_W'(sfe_pkg::MIN_HASH_BITS))
            bits_used = sfe_pkg::HB_W'(sfe_pkg::MIN_HASH_BITS);
        else if (hash_bits_reg > sfe_pkg::HB_W'(MAX_HASH_BITS))
            bits_used = sfe_pkg::HB_W'(MAX_HASH_BITS);
        else
            bits_used = hash_bits_reg;
    end

    sfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    sfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    sfe_back #(
        .MAX_HASH_BITS (MAX_HASH_BITS),
        .ACC_WIDTH     (ACC_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bits_used    (bits_used),
        .head_valid   (q_head_valid),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
